// ===== rtl/two_queue_priority_runway_arbiter_defines.svh =====
// ----------------------------------------------------------------------------
// two_queue_priority_runway_arbiter_defines
// Assertion macros for the two-queue priority arbiter, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef TWO_QUEUE_PRIORITY_RUNWAY_ARBITER_DEFINES_SVH
`define TWO_QUEUE_PRIORITY_RUNWAY_ARBITER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TQPRA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TQPRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TQPRA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define TQPRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/tqpra_pkg.sv =====
// ----------------------------------------------------------------------------
// tqpra_pkg
// Shared types, constants and saturating arithmetic of the arbiter.
// ----------------------------------------------------------------------------
package tqpra_pkg;

  localparam int LIMIT_W = 5;
  localparam int ID_W    = 16;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 32;
  localparam int TOT_W   = 48;
  localparam int IN_W    = 56;   // 2 + 16 + 32, padded to bytes
  localparam int OUT_W   = 376;  // 371 bits of fields, padded to bytes

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic [1:0] MODE_HIGH_REQ = 2'd0;
  localparam logic [1:0] MODE_LOW_REQ  = 2'd1;

  typedef enum logic [2:0] {
    OUT_ACCEPTED    = 3'd0,
    OUT_REFUSED     = 3'd1,
    OUT_SERVED_HIGH = 3'd2,
    OUT_SERVED_LOW  = 3'd3,
    OUT_IDLE        = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    CMD_PUSH_HIGH,
    CMD_PUSH_LOW,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
  } entry_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic has_room;
    logic not_empty;
  } q_sts_t;

  typedef struct packed {
    logic [CNT_W-1:0] idle_ticks;
    logic [TOT_W-1:0] low_wait_total;
    logic [TOT_W-1:0] high_wait_total;
    logic [CNT_W-1:0] low_served;
    logic [CNT_W-1:0] high_served;
    logic [CNT_W-1:0] low_refused;
    logic [CNT_W-1:0] high_refused;
    logic [CNT_W-1:0] low_requests;
    logic [CNT_W-1:0] high_requests;
  } stats_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] t,
                                               input logic [TIME_W-1:0] a);
    logic [TOT_W:0] s;
    s = {1'b0, t} + {{(TOT_W+1-TIME_W){1'b0}}, a};
    return s[TOT_W] ? '1 : s[TOT_W-1:0];
  endfunction

endpackage

// ===== rtl/two_queue_priority_runway_arbiter.sv =====
// ----------------------------------------------------------------------------
// two_queue_priority_runway_arbiter
// Strict-priority two-queue arbiter with admission limit and statistics.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   in_      slave      in_tvalid/in_tready    mode, item_id, now
//   out_     master     out_tvalid/out_tready  outcome, served id/wait, stats
//   cfg_     slave      cfg_valid/cfg_ready    admission limit
//
// A request or an idle tick is executed in the S_IDLE state; a tick that
// serves an entry also passes through S_SERVE, where the registered read of
// the class queue memory arrives. Commands pass through the input register
// and the two-entry command queue. Reset is synchronous and needs no clearing pass. The
// result register holds while out_tready is low; the front keeps accepting
// until the command queue fills.
// ----------------------------------------------------------------------------
`include "two_queue_priority_runway_arbiter_defines.svh"

module two_queue_priority_runway_arbiter #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // mode[1:0], item_id[17:2], now[49:18], zero pad
  input  logic [tqpra_pkg::IN_W-1:0]          in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // outcome[2:0], served_id[18:3], served_wait[50:19], high_requests[82:51],
  // low_requests[114:83], high_refused[146:115], low_refused[178:147],
  // high_served[210:179], low_served[242:211], high_wait_total[290:243],
  // low_wait_total[338:291], idle_ticks[370:339], zero pad
  output logic [tqpra_pkg::OUT_W-1:0]         out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tqpra_pkg::LIMIT_W-1:0]       cfg_data
);
  import tqpra_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic               cmd_wr;
  cmd_t               cmd_in;
  logic               cmd_full;
  logic               cmd_pop;
  logic               cmd_valid;
  cmd_t               cmd_head;
  q_ctl_t             hi_ctl;
  q_ctl_t             lo_ctl;
  q_sts_t             hi_sts;
  q_sts_t             lo_sts;
  entry_t             wr_entry;
  entry_t             hi_rd;
  entry_t             lo_rd;
  outcome_t           outcome;
  logic [ID_W-1:0]    served_id;
  logic [TIME_W-1:0]  served_wait;
  stats_t             stats;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  tqpra_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cmd_wr    (cmd_wr),
    .cmd_out   (cmd_in),
    .cmd_full  (cmd_full)
  );

  tqpra_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cmd_wr),
    .wr_data  (cmd_in),
    .full     (cmd_full),
    .rd_en    (cmd_pop),
    .rd_valid (cmd_valid),
    .rd_data  (cmd_head)
  );

  tqpra_class_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_high_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (hi_ctl),
    .wr_entry (wr_entry),
    .limit    (limit_r),
    .sts      (hi_sts),
    .rd_entry (hi_rd)
  );

  tqpra_class_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_low_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (lo_ctl),
    .wr_entry (wr_entry),
    .limit    (limit_r),
    .sts      (lo_sts),
    .rd_entry (lo_rd)
  );

  tqpra_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd_head),
    .cmd_pop     (cmd_pop),
    .hi_ctl      (hi_ctl),
    .lo_ctl      (lo_ctl),
    .wr_entry    (wr_entry),
    .hi_sts      (hi_sts),
    .lo_sts      (lo_sts),
    .hi_rd       (hi_rd),
    .lo_rd       (lo_rd),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .outcome     (outcome),
    .served_id   (served_id),
    .served_wait (served_wait),
    .stats       (stats)
  );

  assign out_tdata = {5'b0, stats, served_wait, served_id, outcome};

  `TQPRA_ASSERT_SAME(a_no_pop_empty, clk, rst_n, hi_ctl.pop || lo_ctl.pop, (hi_ctl.pop && hi_sts.not_empty) || (lo_ctl.pop && lo_sts.not_empty), "pop from an empty class queue")
  `TQPRA_ASSERT_SAME(a_no_push_full, clk, rst_n, hi_ctl.push || lo_ctl.push, (hi_ctl.push && hi_sts.has_room) || (lo_ctl.push && lo_sts.has_room), "push into a class queue without room")
  `TQPRA_ASSERT_SAME(a_one_queue_op, clk, rst_n, 1'b1, $onehot0({hi_ctl, lo_ctl}), "more than one queue operation in a cycle")
  `TQPRA_ASSERT_SAME(a_zero_limit, clk, rst_n, limit_r == '0, !hi_sts.has_room && !lo_sts.has_room, "room reported under a zero limit")
  `TQPRA_ASSERT_NEXT(a_serve_slot, clk, rst_n, hi_ctl.pop || lo_ctl.pop, !out_tvalid, "result register busy while a tick is served")

endmodule

// ===== rtl/tqpra_front.sv =====
// ----------------------------------------------------------------------------
// tqpra_front
// Input register: takes stream items and classifies them into commands.
// ----------------------------------------------------------------------------
module tqpra_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [tqpra_pkg::IN_W-1:0] in_tdata,
  output logic                     cmd_wr,
  output tqpra_pkg::cmd_t          cmd_out,
  input  logic                     cmd_full
);
  import tqpra_pkg::*;

  logic vld_r;
  logic vld_nxt;
  cmd_t cmd_r;
  cmd_t cmd_nxt;
  logic take;

  assign in_tready = !vld_r || !cmd_full;
  assign take      = in_tvalid && in_tready;
  assign cmd_wr    = vld_r && !cmd_full;
  assign cmd_out   = cmd_r;

  always_comb begin
    vld_nxt = vld_r && cmd_full;
    cmd_nxt = cmd_r;
    if (take) begin
      vld_nxt     = 1'b1;
      cmd_nxt.id  = in_tdata[17:2];
      cmd_nxt.now = in_tdata[49:18];
      case (in_tdata[1:0])
        MODE_HIGH_REQ: cmd_nxt.kind = CMD_PUSH_HIGH;
        MODE_LOW_REQ:  cmd_nxt.kind = CMD_PUSH_LOW;
        default:       cmd_nxt.kind = CMD_TICK;  // unused mode serves as a tick
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

// ===== rtl/tqpra_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// tqpra_cmd_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module tqpra_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  tqpra_pkg::cmd_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output logic            rd_valid,
  output tqpra_pkg::cmd_t rd_data
);
  import tqpra_pkg::*;

  localparam int DEPTH = 2;

  cmd_t       ent_r [DEPTH];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'(DEPTH));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= rp_r + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r[wp_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/tqpra_class_queue.sv =====
// ----------------------------------------------------------------------------
// tqpra_class_queue
// One bounded class queue: entry memory with registered read, head, tail
// and fill count with admission against the configured limit.
// ----------------------------------------------------------------------------
module tqpra_class_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tqpra_pkg::q_ctl_t               ctl,
  input  tqpra_pkg::entry_t               wr_entry,
  input  logic [tqpra_pkg::LIMIT_W-1:0]   limit,
  output tqpra_pkg::q_sts_t               sts,
  output tqpra_pkg::entry_t               rd_entry
);
  import tqpra_pkg::*;

  localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

  entry_t        mem [QUEUE_DEPTH];
  logic [PW-1:0] head_r;
  logic [PW-1:0] tail_r;
  logic [CW-1:0] cnt_r;
  entry_t        rd_r;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign sts.not_empty = (cnt_r != '0);
  assign sts.has_room  = (CMPW'(cnt_r) < CMPW'(limit)) && (cnt_r < CW'(QUEUE_DEPTH));
  assign rd_entry      = rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (ctl.push) begin
        tail_r <= wrap_inc(tail_r);
      end
      if (ctl.pop) begin
        head_r <= wrap_inc(head_r);
      end
      case ({ctl.push, ctl.pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= wr_entry;
    end
    if (ctl.pop) begin
      rd_r <= mem[head_r];
    end
  end

endmodule

// ===== rtl/tqpra_back.sv =====
// ----------------------------------------------------------------------------
// tqpra_back
// Command executor: admits requests, serves ticks by strict priority,
// keeps the saturating statistics and holds the result register.
// ----------------------------------------------------------------------------
module tqpra_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  input  tqpra_pkg::cmd_t                   cmd,
  output logic                              cmd_pop,
  output tqpra_pkg::q_ctl_t                 hi_ctl,
  output tqpra_pkg::q_ctl_t                 lo_ctl,
  output tqpra_pkg::entry_t                 wr_entry,
  input  tqpra_pkg::q_sts_t                 hi_sts,
  input  tqpra_pkg::q_sts_t                 lo_sts,
  input  tqpra_pkg::entry_t                 hi_rd,
  input  tqpra_pkg::entry_t                 lo_rd,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tqpra_pkg::outcome_t               outcome,
  output logic [tqpra_pkg::ID_W-1:0]        served_id,
  output logic [tqpra_pkg::TIME_W-1:0]      served_wait,
  output tqpra_pkg::stats_t                 stats
);
  import tqpra_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SERVE
  } state_t;

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  outcome_t            outcome_r, outcome_nxt;
  logic [ID_W-1:0]     sid_r, sid_nxt;
  logic [TIME_W-1:0]   wait_r, wait_nxt;
  stats_t              stats_r, stats_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic                serve_hi_r, serve_hi_nxt;

  logic                slot_free;
  entry_t              head_ent;
  logic [TIME_W-1:0]   wait_calc;

  assign slot_free   = !out_valid_r || out_ready;
  assign head_ent    = serve_hi_r ? hi_rd : lo_rd;
  assign wait_calc   = now_r - head_ent.arrival;
  assign wr_entry    = '{id: cmd.id, arrival: cmd.now};

  assign out_valid   = out_valid_r;
  assign outcome     = outcome_r;
  assign served_id   = sid_r;
  assign served_wait = wait_r;
  assign stats       = stats_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    outcome_nxt   = outcome_r;
    sid_nxt       = sid_r;
    wait_nxt      = wait_r;
    stats_nxt     = stats_r;
    now_nxt       = now_r;
    serve_hi_nxt  = serve_hi_r;
    cmd_pop       = 1'b0;
    hi_ctl        = '0;
    lo_ctl        = '0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_pop  = 1'b1;
          sid_nxt  = '0;
          wait_nxt = '0;
          case (cmd.kind)
            CMD_PUSH_HIGH: begin
              out_valid_nxt           = 1'b1;
              stats_nxt.high_requests = sat_inc(stats_r.high_requests);
              if (hi_sts.has_room) begin
                hi_ctl.push = 1'b1;
                outcome_nxt = OUT_ACCEPTED;
              end else begin
                stats_nxt.high_refused = sat_inc(stats_r.high_refused);
                outcome_nxt            = OUT_REFUSED;
              end
            end
            CMD_PUSH_LOW: begin
              out_valid_nxt          = 1'b1;
              stats_nxt.low_requests = sat_inc(stats_r.low_requests);
              if (lo_sts.has_room) begin
                lo_ctl.push = 1'b1;
                outcome_nxt = OUT_ACCEPTED;
              end else begin
                stats_nxt.low_refused = sat_inc(stats_r.low_refused);
                outcome_nxt           = OUT_REFUSED;
              end
            end
            default: begin
              now_nxt = cmd.now;
              if (hi_sts.not_empty) begin
                hi_ctl.pop   = 1'b1;
                serve_hi_nxt = 1'b1;
                state_nxt    = S_SERVE;
              end else if (lo_sts.not_empty) begin
                lo_ctl.pop   = 1'b1;
                serve_hi_nxt = 1'b0;
                state_nxt    = S_SERVE;
              end else begin
                out_valid_nxt        = 1'b1;
                stats_nxt.idle_ticks = sat_inc(stats_r.idle_ticks);
                outcome_nxt          = OUT_IDLE;
              end
            end
          endcase
        end
      end
      S_SERVE: begin
        // head entry arrives from the queue memory this cycle
        out_valid_nxt = 1'b1;
        sid_nxt       = head_ent.id;
        wait_nxt      = wait_calc;
        state_nxt     = S_IDLE;
        if (serve_hi_r) begin
          outcome_nxt               = OUT_SERVED_HIGH;
          stats_nxt.high_served     = sat_inc(stats_r.high_served);
          stats_nxt.high_wait_total = sat_add(stats_r.high_wait_total, wait_calc);
        end else begin
          outcome_nxt              = OUT_SERVED_LOW;
          stats_nxt.low_served     = sat_inc(stats_r.low_served);
          stats_nxt.low_wait_total = sat_add(stats_r.low_wait_total, wait_calc);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      outcome_r   <= OUT_ACCEPTED;
      sid_r       <= '0;
      wait_r      <= '0;
      stats_r     <= '0;
      now_r       <= '0;
      serve_hi_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      outcome_r   <= outcome_nxt;
      sid_r       <= sid_nxt;
      wait_r      <= wait_nxt;
      stats_r     <= stats_nxt;
      now_r       <= now_nxt;
      serve_hi_r  <= serve_hi_nxt;
    end
  end

endmodule

// ===== test/tqpra_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tqpra_checker
// Watches the request, result and limit channels of the arbiter, keeps its
// own model of both class queues and all statistics, and compares every
// result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tqpra_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [tqpra_pkg::IN_W-1:0]    in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [tqpra_pkg::OUT_W-1:0]   out_tdata,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [tqpra_pkg::LIMIT_W-1:0] cfg_data,
  output int                            failures,
  output int                            pending
);
  import tqpra_pkg::*;

  typedef struct {
    outcome_t          outcome;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] wait_time;
    stats_t            stats;
  } grant_t;

  grant_t              predicted_grants[$];
  entry_t              high_waiting[$];
  entry_t              low_waiting[$];
  stats_t              tally;
  logic [LIMIT_W-1:0]  admit_limit;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] cnt);
    return (cnt == {CNT_W{1'b1}}) ? cnt : cnt + CNT_W'(1);
  endfunction

  function automatic logic [TOT_W-1:0] accumulate(input logic [TOT_W-1:0] total,
                                                  input logic [TIME_W-1:0] amount);
    logic [TOT_W:0] sum;
    sum = {1'b0, total} + {{(TOT_W+1-TIME_W){1'b0}}, amount};
    return sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];
  endfunction

  function automatic void check_field(input string name, input logic [TOT_W-1:0] want,
                                      input logic [TOT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  task automatic predict_arbitration(input logic [1:0] mode, input logic [ID_W-1:0] id,
                                     input logic [TIME_W-1:0] now);
    grant_t      g;
    entry_t      slot;
    int unsigned room;
    room = (admit_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : admit_limit;
    g.id = '0;
    g.wait_time = '0;
    slot.id = id;
    slot.arrival = now;
    if (mode == MODE_HIGH_REQ) begin
      tally.high_requests = bump(tally.high_requests);
      if (high_waiting.size() < room) begin
        high_waiting.push_back(slot);
        g.outcome = OUT_ACCEPTED;
      end else begin
        tally.high_refused = bump(tally.high_refused);
        g.outcome = OUT_REFUSED;
      end
    end else if (mode == MODE_LOW_REQ) begin
      tally.low_requests = bump(tally.low_requests);
      if (low_waiting.size() < room) begin
        low_waiting.push_back(slot);
        g.outcome = OUT_ACCEPTED;
      end else begin
        tally.low_refused = bump(tally.low_refused);
        g.outcome = OUT_REFUSED;
      end
    end else if (high_waiting.size() != 0) begin
      // any other mode is a tick: high class first
      slot = high_waiting.pop_front();
      g.id = slot.id;
      g.wait_time = now - slot.arrival;
      tally.high_wait_total = accumulate(tally.high_wait_total, g.wait_time);
      tally.high_served = bump(tally.high_served);
      g.outcome = OUT_SERVED_HIGH;
    end else if (low_waiting.size() != 0) begin
      slot = low_waiting.pop_front();
      g.id = slot.id;
      g.wait_time = now - slot.arrival;
      tally.low_wait_total = accumulate(tally.low_wait_total, g.wait_time);
      tally.low_served = bump(tally.low_served);
      g.outcome = OUT_SERVED_LOW;
    end else begin
      tally.idle_ticks = bump(tally.idle_ticks);
      g.outcome = OUT_IDLE;
    end
    g.stats = tally;
    predicted_grants.push_back(g);
  endtask

  always @(posedge clk) begin : watch
    grant_t want;
    stats_t got_stats;
    if (!rst_n) begin
      predicted_grants.delete();
      high_waiting.delete();
      low_waiting.delete();
      tally = '0;
      admit_limit = LIMIT_RESET;
      failures = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (predicted_grants.size() == 0) begin
          $error("result transfer with no prediction waiting");
          failures++;
        end else begin
          want = predicted_grants.pop_front();
          got_stats = out_tdata[370:51];
          check_field("outcome", TOT_W'(want.outcome), TOT_W'(out_tdata[2:0]));
          check_field("served_id", TOT_W'(want.id), TOT_W'(out_tdata[18:3]));
          check_field("served_wait", TOT_W'(want.wait_time), TOT_W'(out_tdata[50:19]));
          check_field("high_requests", TOT_W'(want.stats.high_requests),
                      TOT_W'(got_stats.high_requests));
          check_field("low_requests", TOT_W'(want.stats.low_requests),
                      TOT_W'(got_stats.low_requests));
          check_field("high_refused", TOT_W'(want.stats.high_refused),
                      TOT_W'(got_stats.high_refused));
          check_field("low_refused", TOT_W'(want.stats.low_refused),
                      TOT_W'(got_stats.low_refused));
          check_field("high_served", TOT_W'(want.stats.high_served),
                      TOT_W'(got_stats.high_served));
          check_field("low_served", TOT_W'(want.stats.low_served),
                      TOT_W'(got_stats.low_served));
          check_field("high_wait_total", want.stats.high_wait_total,
                      got_stats.high_wait_total);
          check_field("low_wait_total", want.stats.low_wait_total, got_stats.low_wait_total);
          check_field("idle_ticks", TOT_W'(want.stats.idle_ticks),
                      TOT_W'(got_stats.idle_ticks));
        end
      end
      if (in_tvalid && in_tready) begin
        predict_arbitration(in_tdata[1:0], in_tdata[17:2], in_tdata[49:18]);
      end
      if (cfg_valid && cfg_ready) begin
        admit_limit = cfg_data;
      end
    end
    pending <= predicted_grants.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests and service ticks into the two-queue priority arbiter
// under several admission limits and handshake pressure patterns; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import tqpra_pkg::*;

  localparam logic [1:0] MODE_TICK     = 2'd2;
  localparam logic [1:0] MODE_TICK_ALT = 2'd3;
  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         SETTLE_CYCLES = 12;
  localparam int         NUM_PHASES    = 8;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // mode[1:0], item_id[17:2], now[49:18], zero pad
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  // outcome[2:0], served_id[18:3], served_wait[50:19], stats[370:51], zero pad
  logic [OUT_W-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [LIMIT_W-1:0] cfg_data;

  int failures;
  int pending;
  int cycle_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  logic [TIME_W-1:0] clock_now;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  two_queue_priority_runway_arbiter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  tqpra_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .failures   (failures),
    .pending    (pending)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] now);
    // valid only drops while a gap is taken, never between back-to-back transfers
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_W'({$urandom, $urandom});
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - 50){1'b0}}, now, id, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item(input int req_pct);
    logic [1:0] mode;
    if ($urandom_range(99) < req_pct) begin
      mode = $urandom_range(1) ? MODE_HIGH_REQ : MODE_LOW_REQ;
    end else begin
      mode = ($urandom_range(7) == 0) ? MODE_TICK_ALT : MODE_TICK;
    end
    // mostly a steadily advancing clock, now and then an arbitrary time
    if ($urandom_range(9) == 0) begin
      clock_now = $urandom;
    end else begin
      clock_now = clock_now + $urandom_range(50);
    end
    send_item(mode, ID_W'($urandom), clock_now);
  endtask

  int phase_limit[NUM_PHASES] = '{31, 2, 16, 5, 0, 17, 1, 8};
  int phase_gap[NUM_PHASES]   = '{0, 80, 0, 14, 0, 80, 0, 14};
  int phase_stall[NUM_PHASES] = '{0, 0, 80, 14, 0, 0, 80, 14};
  int phase_items[NUM_PHASES] = '{250, 250, 250, 250, 60, 250, 250, 250};
  int bias_choice[4]          = '{30, 50, 70, 90};

  initial begin
    int req_pct;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit: field extremes, wrapped wait, both tick modes, idle ticks
    send_item(MODE_HIGH_REQ, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(MODE_LOW_REQ, 16'h0000, 32'h0000_0000);
    send_item(MODE_TICK, 16'hFFFF, 32'h0000_0000);
    send_item(MODE_TICK_ALT, 16'h0000, 32'hFFFF_FFFF);
    send_item(MODE_TICK, 16'h1234, 32'h0000_0005);
    send_item(MODE_TICK_ALT, 16'hFFFF, 32'hFFFF_FFFF);
    drain();

    // zero limit refuses every request
    write_limit(5'd0);
    send_item(MODE_HIGH_REQ, 16'hA5A5, 32'h0000_0010);
    send_item(MODE_LOW_REQ, 16'h5A5A, 32'h0000_0011);
    send_item(MODE_TICK, 16'h0000, 32'h0000_0012);
    drain();

    // limit of one: second request of each class bounces
    write_limit(5'd1);
    send_item(MODE_LOW_REQ, 16'h0001, 32'h8000_0000);
    send_item(MODE_HIGH_REQ, 16'h0002, 32'h8000_0001);
    send_item(MODE_HIGH_REQ, 16'h0003, 32'h8000_0002);
    send_item(MODE_LOW_REQ, 16'h0004, 32'h8000_0003);
    send_item(MODE_TICK, 16'h0000, 32'h8000_0100);
    send_item(MODE_TICK, 16'h0000, 32'h7FFF_FFFF);
    send_item(MODE_TICK, 16'h0000, 32'h8000_0200);
    drain();

    clock_now = $urandom;
    for (int p = 0; p < NUM_PHASES; p++) begin
      gap_pct   = phase_gap[p];
      stall_pct = phase_stall[p];
      write_limit((p == NUM_PHASES - 1) ? LIMIT_W'($urandom_range(31))
                                        : LIMIT_W'(phase_limit[p]));
      req_pct = 50;
      for (int n = 0; n < phase_items[p]; n++) begin
        // swing between filling and draining so both full and empty queues occur
        if (n % 40 == 0) req_pct = bias_choice[$urandom_range(3)];
        random_item(req_pct);
      end
      drain();
    end

    gap_pct   = 0;
    stall_pct = 0;
    if (failures == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tqpra_pkg.sv
rtl/tqpra_front.sv
rtl/tqpra_cmd_fifo.sv
rtl/tqpra_class_queue.sv
rtl/tqpra_back.sv
rtl/two_queue_priority_runway_arbiter.sv
test/tqpra_checker.sv
test/testbench.sv
